@@ src/pse_pkg.sv @@
// pse_pkg: shared constants, codes and controller/datapath structs for the
// postfix stack evaluator. No dependencies.

package pse_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int VALUE_WIDTH_DEF = 8;
  localparam int SYMBOL_W        = 8;
  localparam int OUT_VALUE_W     = 8;
  localparam int ERROR_W         = 2;

  localparam logic [SYMBOL_W-1:0] SYM_ZERO  = 8'h30;  // '0'
  localparam logic [SYMBOL_W-1:0] SYM_PLUS  = 8'h2B;  // '+'
  localparam logic [SYMBOL_W-1:0] SYM_MINUS = 8'h2D;  // '-'
  localparam logic [SYMBOL_W-1:0] SYM_STAR  = 8'h2A;  // '*'
  localparam logic [SYMBOL_W-1:0] SYM_SLASH = 8'h2F;  // '/'

  typedef enum logic [ERROR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_DIV_ZERO  = 2'd2,
    ERR_OVERFLOW  = 2'd3
  } err_code_t;

  // controller -> datapath
  typedef struct packed {
    logic      load_item;
    logic      push_sym;
    logic      push_res;
    logic      rd_second;
    logic      cap_rhs;
    logic      cap_lhs;
    logic      alu_exec;
    logic      div_take;
    logic      set_err;
    err_code_t err;
    logic      emit;
  } pse_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic last;
    logic lt2;
    logic full;
    logic div_op;
    logic rhs_zero;
    logic div_done;
    logic out_full;
  } pse_stat_t;

endpackage

@@ src/pse_if.sv @@
// pse_if: valid/ready channel interfaces for expression symbols and results.
// Depends on pse_pkg.

interface pse_in_if import pse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [OUT_VALUE_W-1:0] value;
  logic        [ERROR_W-1:0]     error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

@@ src/pse_div.sv @@
// pse_div: iterative signed truncating divider, one quotient bit per cycle.
// Depends on pse_pkg (imported for house consistency only through parameters).

module pse_div import pse_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     q;
  logic [W-1:0]     dvs;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [W-1:0] abs_dividend;
  logic [W-1:0] abs_divisor;
  logic [W:0]   rem_sh;
  logic [W:0]   diff;

  assign abs_dividend = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign abs_divisor  = divisor[W-1]  ? (~divisor + W'(1))  : divisor;
  assign rem_sh       = {rem, q[W-1]};
  assign diff         = rem_sh - {1'b0, dvs};
  assign quotient     = neg ? (~q + W'(1)) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= abs_dividend;
      dvs <= abs_divisor;
      neg <= dividend[W-1] ^ divisor[W-1];
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        q   <= {q[W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/pse_datapath.sv @@
// pse_datapath: operand stack memory, count, sticky error, ALU, divider and
// output register. Depends on pse_pkg and pse_div.

module pse_datapath import pse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pse_cmd_t                      cmd,
  output pse_stat_t                     stat,
  input  logic [SYMBOL_W-1:0]           symbol_in,
  input  logic                          last_in,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [OUT_VALUE_W-1:0] out_value,
  output logic [ERROR_W-1:0]            out_error
);

  localparam int W      = VALUE_WIDTH;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

  logic [W-1:0]        mem [STACK_DEPTH];
  logic [W-1:0]        rdata;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;
  logic [CNT_W-1:0]    count;
  err_code_t           err;
  logic [W-1:0]        rhs;
  logic [W-1:0]        lhs;
  logic [W-1:0]        res;

  alu_op_t      alu_op;
  logic         is_op;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [W-1:0] sym_val;
  logic [W-1:0] wdata;
  logic         we;
  logic [W-1:0] prod;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] quotient;

  always_comb begin
    case (symbol)
      SYM_PLUS:  alu_op = ALU_ADD;
      SYM_MINUS: alu_op = ALU_SUB;
      SYM_STAR:  alu_op = ALU_MUL;
      default:   alu_op = ALU_DIV;
    endcase
  end

  assign is_op = (symbol == SYM_PLUS) || (symbol == SYM_MINUS) ||
                 (symbol == SYM_STAR) || (symbol == SYM_SLASH);

  // count wraps to 0 in the address bits only when the depth is a power of two
  assign rd_addr = cmd.rd_second ? (count[ADDR_W-1:0] - ADDR_W'(2))
                                 : (count[ADDR_W-1:0] - ADDR_W'(1));
  assign wr_addr = count[ADDR_W-1:0];
  assign sym_val = W'(symbol) - W'(SYM_ZERO);
  assign wdata   = cmd.push_sym ? sym_val : res;
  assign we      = cmd.push_sym || cmd.push_res;
  assign prod    = W'(lhs * rhs);

  assign div_start = cmd.alu_exec && (alu_op == ALU_DIV) && (rhs != '0);

  pse_div #(.VALUE_WIDTH(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (rhs),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      symbol <= symbol_in;
      last   <= last_in;
    end
    if (cmd.cap_rhs) begin
      rhs <= rdata;
    end
    if (cmd.cap_lhs) begin
      lhs <= rdata;
    end
    if (cmd.alu_exec) begin
      case (alu_op)
        ALU_ADD: res <= lhs + rhs;
        ALU_SUB: res <= lhs - rhs;
        ALU_MUL: res <= prod;
        default: res <= '0;  // divide by zero pushes 0
      endcase
    end else if (cmd.div_take) begin
      res <= quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count <= '0;
        err   <= ERR_NONE;
      end else begin
        if (we) begin
          count <= count + CNT_W'(1);
        end else if (cmd.cap_lhs) begin
          count <= count - CNT_W'(2);
        end
        if (cmd.set_err && (err == ERR_NONE)) begin
          err <= cmd.err;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value <= (count == '0) ? '0 : OUT_VALUE_W'(rdata);
      out_error <= ((count == '0) && (err == ERR_NONE)) ? ERR_UNDERFLOW : err;
    end
  end

  assign stat.is_op    = is_op;
  assign stat.last     = last;
  assign stat.lt2      = (count < CNT_W'(2));
  assign stat.full     = (count == CNT_W'(STACK_DEPTH));
  assign stat.div_op   = (alu_op == ALU_DIV);
  assign stat.rhs_zero = (rhs == '0);
  assign stat.div_done = div_done;
  assign stat.out_full = out_valid;

endmodule

@@ src/pse_ctrl.sv @@
// pse_ctrl: sequencing state machine for the postfix stack evaluator.
// Depends on pse_pkg.

module pse_ctrl import pse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pse_stat_t stat,
  output pse_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RHS,
    S_POP_LHS,
    S_EXEC,
    S_ALU,
    S_DIV,
    S_PUSH,
    S_CHECK,
    S_FIN_READ,
    S_FIN_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.err    = ERR_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_op) begin
          if (stat.lt2) begin
            cmd.set_err = 1'b1;
            cmd.err     = ERR_UNDERFLOW;
            state_next  = S_CHECK;
          end else begin
            state_next = S_POP_RHS;
          end
        end else begin
          if (stat.full) begin
            cmd.set_err = 1'b1;
            cmd.err     = ERR_OVERFLOW;
          end else begin
            cmd.push_sym = 1'b1;
          end
          state_next = S_CHECK;
        end
      end
      S_POP_RHS: begin
        state_next = S_POP_LHS;
      end
      S_POP_LHS: begin
        cmd.rd_second = 1'b1;
        cmd.cap_rhs   = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        cmd.cap_lhs = 1'b1;
        state_next  = S_ALU;
      end
      S_ALU: begin
        cmd.alu_exec = 1'b1;
        if (stat.div_op && stat.rhs_zero) begin
          cmd.set_err = 1'b1;
          cmd.err     = ERR_DIV_ZERO;
          state_next  = S_PUSH;
        end else if (stat.div_op) begin
          state_next = S_DIV;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_PUSH;
        end
      end
      S_PUSH: begin
        if (stat.full) begin
          cmd.set_err = 1'b1;
          cmd.err     = ERR_OVERFLOW;
        end else begin
          cmd.push_res = 1'b1;
        end
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = stat.last ? S_FIN_READ : S_IDLE;
      end
      S_FIN_READ: begin
        state_next = S_FIN_EMIT;
      end
      S_FIN_EMIT: begin
        // hold the top-of-stack read until the output register is free
        if (!stat.out_full) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/postfix_stack_evaluator_top.sv @@
// postfix_stack_evaluator_top: postfix expression evaluator, one symbol per
// transaction. Depends on pse_pkg, pse_if, pse_ctrl, pse_datapath, pse_div.
//
//   channel  modport  payload          transaction
//   expr     sink     symbol, last     one expression character
//   result   source   value, error     one per character with last set
//
// An operator reads its two operands through the registered stack read, runs
// in the ALU or the one-bit-per-cycle divider and pushes its result; an item
// with last set then reads the top of stack into the output register. One
// item is in flight at a time; the output register lets the next item be
// taken while a result waits. A stalled result holds the evaluator only when
// another result is due. Synchronous reset clears the stack count, the error
// and the output valid; stack contents need no clearing.

module postfix_stack_evaluator_top import pse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  pse_in_if.sink      expr,
  pse_out_if.source   result
);

  pse_cmd_t  cmd;
  pse_stat_t stat;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (expr.valid),
    .in_ready (expr.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .symbol_in (expr.symbol),
    .last_in   (expr.last),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_value (result.value),
    .out_error (result.error)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (expr.valid && expr.ready) |=> !expr.ready)
    else $error("evaluator took a second symbol straight after a transaction");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_sym || cmd.push_res) |-> !stat.full)
    else $error("push issued onto a full stack");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.emit))
    else $error("result valid rose without an emit command");

endmodule

@@ tb/sv/tb_postfix_stack_evaluator_top.sv @@
`timescale 1ns / 1ps
// tb_postfix_stack_evaluator_top: self-checking bench for the postfix evaluator.
// Depends on pse_pkg, pse_if and postfix_stack_evaluator_top; a scoreboard
// class predicts each expression result and checks the result channel.

module tb_postfix_stack_evaluator_top;
  import pse_pkg::*;

  localparam int DEPTH       = STACK_DEPTH_DEF;
  localparam int TOTAL_ITEMS = 1050;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    err_code_t              error;
  } eval_result_t;

  // Evaluates the expression alongside the block and holds the results owed.
  class pse_scoreboard;
    logic [VALUE_WIDTH_DEF-1:0] operands [DEPTH];
    int unsigned                depth;
    err_code_t                  first_err;
    eval_result_t               owed [$];
    int                         mismatches;
    int                         checked;
    int                         symbols_seen;
    int                         err_tally [4];

    function new();
      depth        = 0;
      first_err    = ERR_NONE;
      mismatches   = 0;
      checked      = 0;
      symbols_seen = 0;
      foreach (err_tally[i]) err_tally[i] = 0;
    endfunction

    function void latch_error(err_code_t code);
      if (first_err == ERR_NONE) first_err = code;
    endfunction

    function void push_operand(logic [VALUE_WIDTH_DEF-1:0] v);
      if (depth >= DEPTH) begin
        latch_error(ERR_OVERFLOW);
      end else begin
        operands[depth] = v;
        depth++;
      end
    endfunction

    function void note_symbol(logic [SYMBOL_W-1:0] sym, logic is_last);
      int           lhs;
      int           rhs;
      int           res;
      eval_result_t due;
      symbols_seen++;
      if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_STAR || sym == SYM_SLASH) begin
        if (depth < 2) begin
          latch_error(ERR_UNDERFLOW);
        end else begin
          rhs = $signed(operands[depth-1]);
          lhs = $signed(operands[depth-2]);
          depth -= 2;
          case (sym)
            SYM_PLUS:  res = lhs + rhs;
            SYM_MINUS: res = lhs - rhs;
            SYM_STAR:  res = lhs * rhs;
            default: begin
              if (rhs == 0) begin
                latch_error(ERR_DIV_ZERO);
                res = 0;
              end else begin
                res = lhs / rhs;  // truncates toward zero
              end
            end
          endcase
          push_operand(res[VALUE_WIDTH_DEF-1:0]);
        end
      end else begin
        push_operand(sym - SYM_ZERO);
      end
      if (is_last) begin
        if (depth == 0) begin
          latch_error(ERR_UNDERFLOW);
          due.value = '0;
        end else begin
          due.value = operands[depth-1][OUT_VALUE_W-1:0];
        end
        due.error = first_err;
        owed.push_back(due);
        depth     = 0;
        first_err = ERR_NONE;
      end
    endfunction

    function void check_result(logic [OUT_VALUE_W-1:0] value, logic [ERROR_W-1:0] error);
      eval_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: value %0d error %0d", $time, $signed(value), error);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      checked++;
      err_tally[int'(want.error)]++;
      if (value !== want.value) begin
        $display("%0t: value mismatch: expected %0d actual %0d", $time,
                 $signed(want.value), $signed(value));
        mismatches++;
      end
      if (error !== want.error) begin
        $display("%0t: error mismatch: expected %0d actual %0d", $time, want.error, error);
        mismatches++;
      end
    endfunction

    function int owed_count();
      return owed.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  pse_in_if  expr ();
  pse_out_if result ();

  postfix_stack_evaluator_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr),
    .result (result)
  );

  pse_scoreboard sb = new();

  bit hold_request = 1'b0;
  int items_sent   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;

  always #4 clk = ~clk;

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (expr.valid && expr.ready) sb.note_symbol(expr.symbol, expr.last);
      if (result.valid && result.ready) sb.check_result(result.value, result.error);
      if ((expr.valid && expr.ready) || (result.valid && result.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: stall modes of random length, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0, 1:    result.ready <= 1'b1;
          2:       result.ready <= 1'($urandom_range(0, 1));
          default: result.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        expr.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    expr.valid  <= 1'b1;
    expr.symbol <= sym;
    expr.last   <= is_last;
    do @(posedge clk); while (!expr.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_symbol(txt[i], i == txt.len() - 1);
  endtask

  function automatic logic [SYMBOL_W-1:0] pick_operand();
    logic [SYMBOL_W-1:0] s;
    if ($urandom_range(0, 9) < 7) return SYM_ZERO + SYMBOL_W'($urandom_range(0, 9));
    do s = SYMBOL_W'($urandom_range(0, 255));
    while (s == SYM_PLUS || s == SYM_MINUS || s == SYM_STAR || s == SYM_SLASH);
    return s;
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return SYM_PLUS;
      1:       return SYM_MINUS;
      2:       return SYM_STAR;
      default: return SYM_SLASH;
    endcase
  endfunction

  // Well-formed expression; with noise set, some characters are replaced at random
  task automatic send_expression(input int n_operands, input bit noisy);
    int                  held;
    int                  remaining;
    logic [SYMBOL_W-1:0] s;
    held      = 0;
    remaining = n_operands;
    while (remaining > 0 || held > 1) begin
      if (remaining > 0 && (held < 2 || $urandom_range(0, 1) == 1)) begin
        s = pick_operand();
        held++;
        remaining--;
      end else begin
        s = pick_operator();
        held--;
      end
      if (noisy && $urandom_range(0, 7) == 0) s = SYMBOL_W'($urandom_range(0, 255));
      send_symbol(s, remaining == 0 && held == 1);
    end
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++)
      send_symbol(SYMBOL_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // Deep stack: many pushes, then a few operators, the last one closing it
  task automatic send_flood(input int pushes);
    int ops;
    ops = $urandom_range(1, 4);
    for (int i = 0; i < pushes; i++) send_symbol(pick_operand(), 1'b0);
    for (int j = 0; j < ops; j++) send_symbol(pick_operator(), j == ops - 1);
  endtask

  // advance the clock first so the monitor has seen the last accepted symbol
  task automatic drain_results();
    expr.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    bit hold_done;
    bit flood_done;
    bit drain_done;
    int pick;
    hold_done  = 1'b0;
    flood_done = 1'b0;
    drain_done = 1'b0;
    rst         <= 1'b1;
    expr.valid  <= 1'b0;
    expr.symbol <= '0;
    expr.last   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: each operator, wrap, sign, truncation, errors and stickiness
    send_text("0");
    send_text("34+");
    send_text("35-");
    send_text("99*9*");
    send_text("72/");
    send_text("07-2/");
    send_text("50/");
    send_text("+");
    send_text("5+");
    send_text("50/+");
    send_text("123");
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SYM_PLUS, 1'b1);
    // most negative value divided by minus one wraps
    send_symbol(8'hB0, 1'b0);
    send_text("01-/");
    send_flood(DEPTH + 2);
    drain_results();

    while (items_sent < TOTAL_ITEMS) begin
      if (!hold_done && items_sent >= 350) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && items_sent >= 700) begin
        drain_results();
        drain_done = 1'b1;
      end
      if (!flood_done && items_sent >= 500) begin
        send_flood(DEPTH + $urandom_range(0, 2) - 1);
        flood_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75)      send_expression($urandom_range(1, 6), 1'b0);
      else if (pick < 87) send_expression($urandom_range(1, 6), 1'b1);
      else if (pick < 97) send_noise($urandom_range(1, 8));
      else                send_expression($urandom_range(8, 24), 1'b0);
    end
    drain_results();

    $display("Sent %0d symbols, checked %0d results (%0d mismatches).", items_sent,
             sb.checked, sb.mismatches);
    $display("Result error codes: none %0d, underflow %0d, divide by zero %0d, overflow %0d.",
             sb.err_tally[0], sb.err_tally[1], sb.err_tally[2], sb.err_tally[3]);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
